// File: rtl/core/led_matrix_animation_player_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the LED matrix animation player modules.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ANIMATION_PLAYER_CORE_ASSERT_SVH
`define LED_MATRIX_ANIMATION_PLAYER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMAP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lmap_pkg.sv
// ----------------------------------------------------------------------------
// lmap_pkg
// Types, constants and helper functions of the LED matrix animation player.
// ----------------------------------------------------------------------------
package lmap_pkg;

    // Store geometry.
    localparam int FRAME_DEPTH = 256;
    localparam int PIXELS      = 64;
    localparam int PIXEL_W     = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);

    // Pixels at or above PIXELS are never stored or shown.
    localparam logic [PIXEL_W-1:0] PIX_MASK =
        PIXEL_W'((65'(1) << PIXELS) - 65'd1);

    // Request type codes.
    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_SPEED = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Speed select codes.
    localparam logic [1:0] SPEED_SLOW   = 2'd0;
    localparam logic [1:0] SPEED_MEDIUM = 2'd1;
    localparam logic [1:0] SPEED_FAST   = 2'd2;
    localparam logic [1:0] SPEED_MAX    = 2'd3;

    // Tick periods in milliseconds.
    localparam logic [9:0] PERIOD_SLOW   = 10'd1000;
    localparam logic [9:0] PERIOD_MEDIUM = 10'd100;
    localparam logic [9:0] PERIOD_FAST   = 10'd40;
    localparam logic [9:0] PERIOD_MAX    = 10'd33;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [8:0]         frame_count;
        logic [PIXEL_W-1:0] pixel_bits;
        logic [PIXEL_W-1:0] pixel_mask;
        logic [1:0]         speed_code;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_W-1:0] frame_pixels;
        logic [7:0]         frame_index;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;     // apply the beat on the input channel
        logic capture;  // load the output register from the store read
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;     // the pending input beat is a tick that shows a frame
    } t_dp_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Map a speed code to its tick period.
    function automatic logic [9:0] speed_period(input logic [1:0] code);
        logic [9:0] p;
        case (code)
            SPEED_SLOW:   p = PERIOD_SLOW;
            SPEED_MEDIUM: p = PERIOD_MEDIUM;
            SPEED_FAST:   p = PERIOD_FAST;
            SPEED_MAX:    p = PERIOD_MAX;
            default:      p = PERIOD_SLOW;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/lmap_if.sv
// ----------------------------------------------------------------------------
// lmap_if
// Valid/ready channels for requests into and frames out of the player.
// ----------------------------------------------------------------------------
interface lmap_in_if;
    logic               valid;
    logic               ready;
    lmap_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lmap_out_if;
    logic                valid;
    logic                ready;
    lmap_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/lmap_ram.sv
// ----------------------------------------------------------------------------
// lmap_ram
// Generic single-write, single-read RAM with bit write enables and a
// registered read port.
// ----------------------------------------------------------------------------
module lmap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [WIDTH-1:0]         i_wbe,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write only the enabled bits of the addressed word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wbe[b]) begin
                    r_mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/lmap_ctrl.sv
// ----------------------------------------------------------------------------
// lmap_ctrl
// Controller of the animation player: handshakes on both channels and
// sequences the frame store read for an emitting tick.
// ----------------------------------------------------------------------------
`include "led_matrix_animation_player_core_assert.svh"

module lmap_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  lmap_pkg::t_dp_status   i_status,
    output lmap_pkg::t_ctrl_cmd    o_cmd
);
    import lmap_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    // A beat is taken when idle and the output slot is free or being freed.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_status.emit) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: commands to the datapath and the output valid flag.
    always_comb begin
        o_cmd.exec    = accept;
        o_cmd.capture = 1'b0;
        n_out_valid   = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = 1'b0;
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_out_valid   = 1'b1;
            end
            default: begin
                o_cmd.capture = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // The output slot is always empty while the store read is in flight.
    `LMAP_ASSERT_SAME(a_read_slot_free, i_clk, i_rst_n,
        r_state == S_READ, !r_out_valid, "output slot busy during frame read")
    // An emitting tick always starts a store read.
    `LMAP_ASSERT_NEXT(a_emit_reads, i_clk, i_rst_n,
        accept && i_status.emit, r_state == S_READ, "emitting tick without read")
    // A store read always ends with a frame in the output slot.
    `LMAP_ASSERT_NEXT(a_read_fills, i_clk, i_rst_n,
        r_state == S_READ, (r_state == S_IDLE) && r_out_valid,
        "frame read did not fill the output slot")

endmodule

// File: rtl/core/lmap_datapath.sv
// ----------------------------------------------------------------------------
// lmap_datapath
// Datapath of the animation player: frame store, load and playback
// counters, tick timer and the output register.
// ----------------------------------------------------------------------------
`include "led_matrix_animation_player_core_assert.svh"

module lmap_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lmap_pkg::t_in_item    i_item,
    input  lmap_pkg::t_ctrl_cmd   i_cmd,
    output lmap_pkg::t_dp_status  o_status,
    output lmap_pkg::t_out_item   o_item
);
    import lmap_pkg::*;

    // Control state.
    logic                   r_loading;
    logic                   r_ready;
    logic [8:0]             r_expected;
    logic [8:0]             r_saved;
    logic [7:0]             r_play;
    logic [9:0]             r_tick;
    logic [9:0]             r_period;
    logic [FRAME_DEPTH-1:0] r_valid;

    // Read tracking and output payload.
    logic                   r_rd_valid;
    logic [7:0]             r_rd_index;
    t_out_item              r_out;

    logic                   is_frame;
    logic                   is_speed;
    logic                   is_tick;
    logic                   wr_in_range;
    logic                   rd_in_range;
    logic                   ram_we;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    logic [PIXEL_W-1:0]     wmask;
    logic [PIXEL_W-1:0]     wbe;
    logic [PIXEL_W-1:0]     wdata;
    logic [PIXEL_W-1:0]     rdata;
    logic [8:0]             saved_inc;
    logic                   arm;
    logic                   play_wrap;
    logic                   tick_wrap;

    // Request decode.
    assign is_frame = i_item.req_type == REQ_FRAME;
    assign is_speed = i_item.req_type == REQ_SPEED;
    assign is_tick  = i_item.req_type == REQ_TICK;

    assign o_status.emit = is_tick && r_ready && (r_tick == 10'd0);

    // Masked write into the next slot; a slot never written reads as zero,
    // so its first write takes all bits.
    assign waddr       = ADDR_W'(r_saved);
    assign wr_in_range = 32'(r_saved) < FRAME_DEPTH;
    assign wmask       = i_item.pixel_mask & PIX_MASK;
    assign wbe         = r_valid[waddr] ? wmask : {PIXEL_W{1'b1}};
    assign wdata       = i_item.pixel_bits & wmask;
    assign ram_we      = i_cmd.exec && is_frame && r_loading && wr_in_range;

    // The read port always follows the play position.
    assign raddr       = ADDR_W'(r_play);
    assign rd_in_range = 32'(r_play) < FRAME_DEPTH;

    lmap_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_wbe   (wbe),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Counter arithmetic.
    assign saved_inc = r_saved + 9'd1;
    assign arm       = saved_inc == r_expected;
    assign play_wrap = ({1'b0, r_play} + 9'd1 >= r_expected) || (r_play == 8'd255);
    assign tick_wrap = ({1'b0, r_tick} + 11'd1) >= {1'b0, r_period};

    // Load, speed and playback state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading  <= 1'b0;
            r_ready    <= 1'b0;
            r_expected <= 9'd0;
            r_saved    <= 9'd0;
            r_play     <= 8'd0;
            r_tick     <= 10'd0;
            r_period   <= PERIOD_SLOW;
            r_valid    <= '0;
        end else if (i_cmd.exec) begin
            if (is_frame) begin
                if (!r_loading) begin
                    r_ready    <= 1'b0;
                    r_loading  <= 1'b1;
                    r_expected <= i_item.frame_count;
                    r_saved    <= 9'd0;
                end else begin
                    if (wr_in_range) begin
                        r_valid[waddr] <= 1'b1;
                    end
                    r_saved <= saved_inc;
                    if (arm) begin
                        r_ready   <= 1'b1;
                        r_loading <= 1'b0;
                        r_play    <= 8'd0;
                        r_tick    <= 10'd0;
                    end
                end
            end else if (is_speed) begin
                r_period <= speed_period(i_item.speed_code);
            end else if (is_tick && r_ready) begin
                if (r_tick == 10'd0) begin
                    r_play <= play_wrap ? 8'd0 : r_play + 8'd1;
                end
                r_tick <= tick_wrap ? 10'd0 : r_tick + 10'd1;
            end
        end
    end

    // Remember which frame is being read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && o_status.emit) begin
            r_rd_valid <= rd_in_range && r_valid[raddr];
            r_rd_index <= r_play;
        end
    end

    // Output register, loaded when the read data arrives.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out.frame_pixels <= r_rd_valid ? (rdata & PIX_MASK) : '0;
            r_out.frame_index  <= r_rd_index;
        end
    end

    assign o_item = r_out;

    // Loading and playing never overlap.
    `LMAP_ASSERT_SAME(a_load_xor_play, i_clk, i_rst_n,
        1'b1, !(r_loading && r_ready), "loading and ready both set")
    // The last announced line arms playback.
    `LMAP_ASSERT_NEXT(a_last_line_arms, i_clk, i_rst_n,
        i_cmd.exec && is_frame && r_loading && arm,
        r_ready && (r_play == 8'd0) && (r_tick == 10'd0), "load end did not arm")
    // The play position stays inside the announced count.
    `LMAP_ASSERT_SAME(a_play_in_range, i_clk, i_rst_n,
        r_ready && (r_expected != 9'd0), {1'b0, r_play} < r_expected,
        "play index beyond frame count")

endmodule

// File: rtl/core/led_matrix_animation_player_core.sv
// ----------------------------------------------------------------------------
// led_matrix_animation_player_core
// Output path: a tick that shows a frame passes the S_READ state before its
// output beat is registered; the frame store read port is registered.
// Throughput: one request per cycle while the output slot is free or being
// freed; an emitting tick holds the input while the store is read.
// Reset: synchronous; clears the control state and all frame valid flags at
// once, so the store reads as all zeros with no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_animation_player_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmap_in_if.sink    i_in,
    lmap_out_if.source o_out
);
    import lmap_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Handshake and sequencing.
    lmap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Store, counters and output register.
    lmap_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.payload),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_out.payload)
    );

endmodule
